/* hdl/sirf_pkg.sv */
// shared types, constants and microcode rom of the signed integer radix formatter
`timescale 1ns / 1ps
`default_nettype none

package sirf_pkg;

  localparam int DEF_MAX_RADIX   = 16;
  localparam int DEF_NUMBER_BITS = 32;

  localparam int SYM_COUNT = 16;
  localparam int SYM_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int RADIX_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RST_RADIX        = 5'd10;
  localparam logic [CFG_W-1:0]   RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] WS_LO      = 8'd9;
  localparam logic [7:0] WS_HI      = 8'd13;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_CHECK,
    ST_DIV,
    ST_PUSH,
    ST_SIGN,
    ST_MINUS,
    ST_DIGIT,
    ST_END
  } step_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_MINUS,
    EMIT_DIGIT
  } emit_e;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_BAD_ALPHA,
    J_DIV_BUSY,
    J_MAG_NZ,
    J_POSITIVE,
    J_MORE_DIGITS
  } jcond_e;

  typedef struct packed {
    logic   take;
    logic   div;
    logic   push;
    emit_e  emit;
    jcond_e jcond;
    step_e  target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic alpha_ok;
    logic neg;
    logic mag_nz;
    logic div_last;
    logic push_room;
    logic digits_left;
  } stat_t;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '{take: 1'b0, div: 1'b0, push: 1'b0, emit: EMIT_NONE,
          jcond: J_NEVER, target: ST_WAIT};
    unique case (s)
      ST_WAIT: begin
        c.take = 1'b1;
      end
      ST_CHECK: begin
        c.jcond  = J_BAD_ALPHA;
        c.target = ST_WAIT;
      end
      ST_DIV: begin
        c.div    = 1'b1;
        c.jcond  = J_DIV_BUSY;
        c.target = ST_DIV;
      end
      ST_PUSH: begin
        c.push   = 1'b1;
        c.jcond  = J_MAG_NZ;
        c.target = ST_DIV;
      end
      ST_SIGN: begin
        c.jcond  = J_POSITIVE;
        c.target = ST_DIGIT;
      end
      ST_MINUS: begin
        c.emit = EMIT_MINUS;
      end
      ST_DIGIT: begin
        c.emit   = EMIT_DIGIT;
        c.jcond  = J_MORE_DIGITS;
        c.target = ST_DIGIT;
      end
      ST_END: begin
        c.jcond  = J_ALWAYS;
        c.target = ST_WAIT;
      end
      default: begin
        c.jcond  = J_ALWAYS;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/sirf_alpha.sv */
// symbol alphabet validity check
`timescale 1ns / 1ps
`default_nettype none

module sirf_alpha #(
  parameter int MAX_RADIX = sirf_pkg::DEF_MAX_RADIX
) (
  input  wire logic [sirf_pkg::RADIX_W-1:0]            radix_i,
  input  wire logic [sirf_pkg::SYM_COUNT*8-1:0]        sym_tab_i,
  output logic                                         ok_o
);
  import sirf_pkg::*;

  localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(MAX_RADIX);

  logic [RADIX_W-1:0]   r;
  logic [SYM_COUNT-1:0] used;
  logic                 bad;

  always_comb begin
    r    = (radix_i > RADIX_CAP) ? RADIX_CAP : radix_i;
    used = '0;
    bad  = (r < RADIX_W'(2));
    for (int a = 0; a < SYM_COUNT; a++) begin
      used[a] = (RADIX_W'(a) < r);
    end
    for (int a = 0; a < SYM_COUNT; a++) begin
      if (used[a]) begin
        if ((sym_tab_i[8*a +: 8] == CHAR_NUL) || (sym_tab_i[8*a +: 8] == CHAR_PLUS) ||
            (sym_tab_i[8*a +: 8] == CHAR_MINUS) ||
            ((sym_tab_i[8*a +: 8] >= WS_LO) && (sym_tab_i[8*a +: 8] <= WS_HI))) begin
          bad = 1'b1;
        end
      end
      for (int b = a + 1; b < SYM_COUNT; b++) begin
        if (used[b] && (sym_tab_i[8*a +: 8] == sym_tab_i[8*b +: 8])) begin
          bad = 1'b1;
        end
      end
    end
    ok_o = !bad;
  end

endmodule

`default_nettype wire

/* hdl/sirf_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module sirf_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sirf_pkg::stat_t stat_i,
  output sirf_pkg::ctrl_t      ctrl_o,
  output logic                 act_o
);
  import sirf_pkg::*;

  step_e step_q, step_d;
  ctrl_t ctrl;
  logic  stall;
  logic  jump;

  always_comb begin
    ctrl  = ucode(step_q);
    stall = (ctrl.take && !stat_i.in_fire) ||
            ((ctrl.emit != EMIT_NONE) && !stat_i.out_free);
    unique case (ctrl.jcond)
      J_NEVER:       jump = 1'b0;
      J_ALWAYS:      jump = 1'b1;
      J_BAD_ALPHA:   jump = !stat_i.alpha_ok;
      J_DIV_BUSY:    jump = !stat_i.div_last;
      J_MAG_NZ:      jump = stat_i.mag_nz && stat_i.push_room;
      J_POSITIVE:    jump = !stat_i.neg;
      J_MORE_DIGITS: jump = stat_i.digits_left;
      default:       jump = 1'b1;
    endcase
    if (stall) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_e'(step_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign act_o  = !stall;

endmodule

`default_nettype wire

/* hdl/signed_integer_radix_formatter_top.sv */
// signed integer to radix symbol string formatter, top level with datapath
// steps: accept, alphabet check, digit loop (divide, push), sign, output bytes, end
// DIV_STEPS = ceil(NUMBER_BITS / 4); the digit loop divides by the radix 4 bits per cycle
// one number in flight at a time
// bytes leave through a one-entry output register; an invalid alphabet returns to wait with no output
// reset: radix 10, symbols "0123456789", sequencer waits for a transaction
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_radix_formatter_top #(
  parameter int MAX_RADIX   = sirf_pkg::DEF_MAX_RADIX,
  parameter int NUMBER_BITS = sirf_pkg::DEF_NUMBER_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [sirf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [sirf_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((NUMBER_BITS+7)/8)*8-1:0]     s_axis_tdata,  // number
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [7:0]                                m_axis_tdata,  // symbol
  output logic                                      m_axis_tlast
);
  import sirf_pkg::*;

  localparam int DIGIT_W   = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int RW        = DIGIT_W + 1;
  localparam int DIV_STEPS = (NUMBER_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int MAGW      = DIV_STEPS * DIV_BITS;
  localparam int DC_W      = $clog2(DIV_STEPS);
  localparam int CNT_W     = $clog2(NUMBER_BITS + 1);
  localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(MAX_RADIX);
  localparam logic [DC_W-1:0]    DIV_LAST  = DC_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(NUMBER_BITS - 1);

  // configuration
  logic [RADIX_W-1:0] radix_q;
  logic [CFG_W-1:0]   sym_lo_q, sym_hi_q;
  logic [SYM_COUNT*8-1:0] sym_tab;
  logic               alpha_ok;

  // datapath
  logic [MAGW-1:0]    mag_q, mag_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic               neg_q;
  logic [DIGIT_W-1:0] digits_q [NUMBER_BITS];
  logic [CNT_W-1:0]   count_q;
  logic [DC_W-1:0]    divcnt_q;
  logic [7:0]         out_data_q;
  logic               out_last_q, out_valid_q;

  logic [RADIX_W-1:0] r_cap;
  logic [RW-1:0]      act_r;
  logic [RW-1:0]      t;
  logic               ge;
  logic [NUMBER_BITS-1:0] in_num, in_mag;
  logic [SYM_IDX_W-1:0]   sym_idx;
  logic [7:0]         digit_sym;

  ctrl_t ctrl;
  stat_t stat;
  logic  act;
  logic  s_fire;
  logic  out_free;
  logic  emit_fire;

  assign sym_tab = {sym_hi_q, sym_lo_q};

  sirf_alpha #(
    .MAX_RADIX (MAX_RADIX)
  ) u_alpha (
    .radix_i   (radix_q),
    .sym_tab_i (sym_tab),
    .ok_o      (alpha_ok)
  );

  sirf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .act_o  (act)
  );

  assign s_axis_tready = ctrl.take;
  assign s_fire        = s_axis_tvalid && ctrl.take;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit_fire     = act && (ctrl.emit != EMIT_NONE);

  assign in_num = s_axis_tdata[NUMBER_BITS-1:0];
  assign in_mag = in_num[NUMBER_BITS-1] ? (~in_num + NUMBER_BITS'(1)) : in_num;

  assign r_cap = (radix_q > RADIX_CAP) ? RADIX_CAP : radix_q;
  assign act_r = r_cap[RW-1:0];

  assign sym_idx   = SYM_IDX_W'(digits_q[0]);
  assign digit_sym = sym_tab[8*sym_idx +: 8];

  always_comb begin
    stat.in_fire     = s_fire;
    stat.out_free    = out_free;
    stat.alpha_ok    = alpha_ok;
    stat.neg         = neg_q;
    stat.mag_nz      = (mag_q != '0);
    stat.div_last    = (divcnt_q == DIV_LAST);
    stat.push_room   = (count_q != CNT_FULL);
    stat.digits_left = (count_q != CNT_ONE);
  end

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    t     = '0;
    ge    = 1'b0;
    for (int j = 0; j < DIV_BITS; j++) begin
      t     = {rem_d, mag_d[MAGW-1]};
      ge    = (t >= act_r);
      rem_d = ge ? DIGIT_W'(t - act_r) : t[DIGIT_W-1:0];
      mag_d = {mag_d[MAGW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RST_RADIX;
      sym_lo_q    <= RST_SYMBOLS_LOW;
      sym_hi_q    <= RST_SYMBOLS_HIGH;
      count_q     <= '0;
      divcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RADIX:        radix_q  <= cfg_data_i[RADIX_W-1:0];
          CFG_SYMBOLS_LOW:  sym_lo_q <= cfg_data_i;
          CFG_SYMBOLS_HIGH: sym_hi_q <= cfg_data_i;
          default:          ;
        endcase
      end
      if (s_fire) begin
        count_q  <= '0;
        divcnt_q <= '0;
      end else if (act && ctrl.div) begin
        divcnt_q <= divcnt_q + DC_W'(1);
      end else if (act && ctrl.push) begin
        divcnt_q <= '0;
        count_q  <= count_q + CNT_W'(1);
      end else if (act && (ctrl.emit == EMIT_DIGIT)) begin
        count_q  <= count_q - CNT_W'(1);
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mag_q <= MAGW'(in_mag);
      neg_q <= in_num[NUMBER_BITS-1];
      rem_q <= '0;
    end else if (act && ctrl.div) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end else if (act && ctrl.push) begin
      digits_q[0] <= rem_q;
      for (int i = 1; i < NUMBER_BITS; i++) begin
        digits_q[i] <= digits_q[i-1];
      end
      rem_q <= '0;
    end else if (act && (ctrl.emit == EMIT_DIGIT)) begin
      for (int i = 0; i < NUMBER_BITS - 1; i++) begin
        digits_q[i] <= digits_q[i+1];
      end
    end
    if (emit_fire) begin
      if (ctrl.emit == EMIT_MINUS) begin
        out_data_q <= CHAR_MINUS;
        out_last_q <= 1'b0;
      end else begin
        out_data_q <= digit_sym;
        out_last_q <= (count_q == CNT_ONE);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_digit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && (ctrl.emit == EMIT_DIGIT)) |-> (count_q != '0))
    else $error("digit emitted from empty stack");

  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && ctrl.push) |-> (count_q < CNT_W'(NUMBER_BITS)))
    else $error("digit stack overflow");

  a_minus_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && (ctrl.emit == EMIT_MINUS)) |-> neg_q)
    else $error("minus sign for non-negative number");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && (ctrl.emit == EMIT_DIGIT) && (count_q == CNT_ONE)) |=> (count_q == '0))
    else $error("stack not empty after final digit");

endmodule

`default_nettype wire
